FILE: design/baf_pkg.sv
// ============================================================================
// baf_pkg
// Shared types and constants of the box average filter.
// ============================================================================
package baf_pkg;

  localparam int PIX_W       = 8;
  localparam int ROW_W       = 12;
  localparam int COL_OUT_W   = 10;
  localparam int CFG_W       = 11;
  localparam int ADDR_MAX_W  = 12;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam logic [CFG_W-1:0] IMAGE_WIDTH_RESET = 11'd640;

  // Register index, taken from the word address of the configuration port.
  localparam logic REG_IMAGE_WIDTH = 1'b0;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } pixel_in_t;

  typedef struct packed {
    logic [PIX_W-1:0]     mean_value;
    logic [ROW_W-1:0]     centre_row;
    logic [COL_OUT_W-1:0] centre_col;
  } result_t;

  // One classified pixel on its way from the front end to the back end.
  typedef struct packed {
    logic [PIX_W-1:0]      pixel;
    logic [ADDR_MAX_W-1:0] addr;
    logic                  emit;
    logic [ROW_W-1:0]      centre_row;
    logic [COL_OUT_W-1:0]  centre_col;
  } queue_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

FILE: design/box_average_filter.sv
// ============================================================================
// box_average_filter
// Streaming square-window mean filter over grey pixels in raster order.
// ============================================================================
// Pixels enter on the pix channel (pix_valid, pix_stall, pix_data) in raster
// order; frame_start marks the first pixel of an image. A transfer takes
// place at a rising edge with valid high and stall low. For every pixel at
// row and column of at least 2*RADIUS the block delivers one result on the
// res channel: the truncated mean of the (2*RADIUS+1)^2 window and the row
// and column of its centre. Border pixels give no result.
// The block takes one pixel per clock while the queue is not full. A result
// passes through the input queue, whose pop ends with the line store read,
// then the column-sum window, the window sum, the reciprocal multiply and
// the correction into the output register.
// When the receiver stalls, the back end holds and the four-entry queue
// keeps taking pixels; pix_stall rises once the queue is full.
// Reset clears the counters, the queue and the pipeline; image_width
// returns to 640. The line store needs no clearing, so pixels are taken
// right after reset. image_width is written through the APB port at byte
// address 0 and should change only while the block is idle.
// ============================================================================
module box_average_filter
  import baf_pkg::*;
#(
  parameter int RADIUS    = 1,
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        pix_valid,
  output logic        pix_stall,
  input  pixel_in_t   pix_data,
  output logic        res_valid,
  input  logic        res_stall,
  output result_t     res_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic               accept;
  logic [CFG_W-1:0]   image_width;
  queue_entry_t       front_entry;
  queue_entry_t       head;
  queue_status_t      qstat;
  logic               pop;

  // The configuration port answers in the access cycle; only the word
  // address bit selects a register.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_IMAGE_WIDTH) ? 32'(image_width) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= IMAGE_WIDTH_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == REG_IMAGE_WIDTH)) begin
      image_width <= pwdata[CFG_W-1:0];
    end
  end

  // Pixels are held off only by a full queue.
  assign pix_stall = qstat.full;
  assign accept    = pix_valid && !qstat.full;

  baf_front #(
    .RADIUS    (RADIUS),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .pix_in      (pix_data),
    .image_width (image_width),
    .entry       (front_entry)
  );

  baf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_entry (front_entry),
    .pop        (pop),
    .head       (head),
    .status     (qstat)
  );

  baf_back #(
    .RADIUS    (RADIUS),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (!qstat.empty),
    .pop        (pop),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_data   (res_data)
  );

endmodule

FILE: design/baf_front.sv
// ============================================================================
// baf_front
// Raster position tracking and classification of each accepted pixel.
// ============================================================================
module baf_front
  import baf_pkg::*;
#(
  parameter int RADIUS    = 1,
  parameter int MAX_WIDTH = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  pixel_in_t          pix_in,
  input  logic [CFG_W-1:0]   image_width,
  output queue_entry_t       entry
);

  localparam int LINES = 2 * RADIUS;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;

  logic [ROW_W-1:0] row;
  logic [CW-1:0]    col;
  logic [ROW_W-1:0] row_eff;
  logic [CW-1:0]    col_eff;
  logic [WW-1:0]    w_min;
  logic [WW-1:0]    w_eff;
  logic [WW-1:0]    col_inc;
  logic [ADDR_MAX_W-1:0] col_wide;

  // A zero width acts as one, and widths beyond the line store are clamped.
  always_comb begin
    w_min = (image_width == '0) ? WW'(1) : WW'(image_width);
    w_eff = (w_min > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : w_min;
  end

  // A frame start puts the pixel at row zero, column zero.
  assign row_eff  = pix_in.frame_start ? '0 : row;
  assign col_eff  = pix_in.frame_start ? '0 : col;
  assign col_inc  = WW'(col_eff) + WW'(1);
  assign col_wide = ADDR_MAX_W'(col_eff);

  always_comb begin
    entry.pixel      = pix_in.pixel;
    entry.addr       = col_wide;
    entry.emit       = (row_eff >= ROW_W'(LINES)) && (col_eff >= CW'(LINES));
    entry.centre_row = row_eff - ROW_W'(RADIUS);
    entry.centre_col = COL_OUT_W'(col_wide - ADDR_MAX_W'(RADIUS));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
    end else if (accept) begin
      if (col_inc >= w_eff) begin
        col <= '0;
        row <= row_eff + ROW_W'(1);
      end else begin
        col <= col_inc[CW-1:0];
        row <= row_eff;
      end
    end
  end

`ifndef SYNTHESIS
  a_frame_start_col : assert property (@(posedge clk) disable iff (rst)
    accept && pix_in.frame_start && (w_eff > WW'(1)) |=> col == CW'(1))
    else $error("column did not restart at a frame start");
`endif

endmodule

FILE: design/baf_queue.sv
// ============================================================================
// baf_queue
// Short queue of classified pixels between the front and back ends.
// ============================================================================
module baf_queue
  import baf_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  queue_entry_t  push_entry,
  input  logic          pop,
  output queue_entry_t  head,
  output queue_status_t status
);

  queue_entry_t        slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     count;

  assign head         = slots[rd_ptr];
  assign status.full  = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QPTR_W + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPTR_W + 1)'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_push_full : assert property (@(posedge clk) disable iff (rst)
    push |-> !status.full || pop)
    else $error("push into a full queue");
  a_no_pop_empty : assert property (@(posedge clk) disable iff (rst)
    pop |-> !status.empty)
    else $error("pop from an empty queue");
`endif

endmodule

FILE: design/baf_back.sv
// ============================================================================
// baf_back
// Line store, sliding window of column sums, window sum and mean.
// ============================================================================
module baf_back
  import baf_pkg::*;
#(
  parameter int RADIUS    = 1,
  parameter int MAX_WIDTH = 1024
) (
  input  logic         clk,
  input  logic         rst,
  input  queue_entry_t head,
  input  logic         head_valid,
  output logic         pop,
  output logic         res_valid,
  input  logic         res_stall,
  output result_t      res_data
);

  localparam int SIDE     = 2 * RADIUS + 1;
  localparam int LINES    = 2 * RADIUS;
  localparam int AREA     = SIDE * SIDE;
  localparam int CW       = $clog2(MAX_WIDTH);
  localparam int PIX_MAX  = 2 ** PIX_W - 1;
  localparam int COLSUM_W = $clog2(SIDE * PIX_MAX + 1);
  localparam int SUM_W    = $clog2(AREA * PIX_MAX + 1);
  localparam int PROD_W   = 2 * SUM_W;
  localparam int RECIP    = (2 ** SUM_W) / AREA;
  localparam int WORD_W   = LINES * PIX_W;

  typedef struct packed {
    logic [ROW_W-1:0]     centre_row;
    logic [COL_OUT_W-1:0] centre_col;
  } coord_t;

  logic                 en;
  logic [WORD_W-1:0]    line_mem [MAX_WIDTH];
  logic [WORD_W-1:0]    rdata;
  logic [WORD_W-1:0]    fwd_word;
  logic                 fwd_hit;
  logic [WORD_W-1:0]    lines_word;
  logic [WORD_W-1:0]    new_word;
  logic [PIX_W-1:0]     col_pix [SIDE];
  logic [COLSUM_W-1:0]  col_sum;
  logic [COLSUM_W-1:0]  colsums [SIDE];
  logic [SUM_W-1:0]     win_sum;

  logic                 s1_valid;
  queue_entry_t         s1_entry;
  logic                 s2_valid;
  coord_t               s2_tag;
  logic                 s3_valid;
  coord_t               s3_tag;
  logic [SUM_W-1:0]     s3_sum;
  logic                 s4_valid;
  coord_t               s4_tag;
  logic [SUM_W-1:0]     s4_sum;
  logic [SUM_W-1:0]     s4_q;
  logic [PROD_W-1:0]    prod;
  logic [SUM_W-1:0]     rem;
  logic [SUM_W-1:0]     rem_fix;
  logic [SUM_W-1:0]     mean;

  // The whole back end advances together whenever the output can move.
  assign en  = !res_valid || !res_stall;
  assign pop = en && head_valid;

  // Line store: one read and one write per advance. The write is the
  // shifted column of the item in stage one.
  always_ff @(posedge clk) begin
    if (en) begin
      if (s1_valid) begin
        line_mem[s1_entry.addr[CW-1:0]] <= new_word;
      end
      rdata <= line_mem[head.addr[CW-1:0]];
    end
  end

  // A read that collides with the write of the same edge sees the new word.
  always_comb begin
    lines_word = fwd_hit ? fwd_word : rdata;
    for (int k = 0; k < LINES; k++) begin
      col_pix[k] = lines_word[k*PIX_W +: PIX_W];
    end
    col_pix[LINES] = s1_entry.pixel;
    for (int k = 0; k < LINES; k++) begin
      new_word[k*PIX_W +: PIX_W] = col_pix[k+1];
    end
    col_sum = '0;
    for (int k = 0; k < SIDE; k++) begin
      col_sum = col_sum + COLSUM_W'(col_pix[k]);
    end
  end

  always_comb begin
    win_sum = '0;
    for (int x = 0; x < SIDE; x++) begin
      win_sum = win_sum + SUM_W'(colsums[x]);
    end
  end

  assign prod = PROD_W'(s3_sum) * PROD_W'(RECIP);

  // The reciprocal estimate is at most one low; one compare corrects it.
  always_comb begin
    rem     = s4_sum - SUM_W'(s4_q * SUM_W'(AREA));
    mean    = (rem >= SUM_W'(AREA)) ? s4_q + SUM_W'(1) : s4_q;
    rem_fix = (rem >= SUM_W'(AREA)) ? rem - SUM_W'(AREA) : rem;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_entry <= head;
      fwd_hit  <= head_valid && s1_valid && (head.addr == s1_entry.addr);
      fwd_word <= new_word;
      s2_tag.centre_row <= s1_entry.centre_row;
      s2_tag.centre_col <= s1_entry.centre_col;
      s3_tag   <= s2_tag;
      s3_sum   <= win_sum;
      s4_tag   <= s3_tag;
      s4_sum   <= s3_sum;
      s4_q     <= prod[PROD_W-1:SUM_W];
      res_data.mean_value <= mean[PIX_W-1:0];
      res_data.centre_row <= s4_tag.centre_row;
      res_data.centre_col <= s4_tag.centre_col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      res_valid <= 1'b0;
      for (int x = 0; x < SIDE; x++) begin
        colsums[x] <= '0;
      end
    end else if (en) begin
      s1_valid  <= head_valid;
      s2_valid  <= s1_valid && s1_entry.emit;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      res_valid <= s4_valid;
      if (s1_valid) begin
        for (int x = 0; x < SIDE - 1; x++) begin
          colsums[x] <= colsums[x+1];
        end
        colsums[SIDE-1] <= col_sum;
      end
    end
  end

`ifndef SYNTHESIS
  a_fwd_needs_item : assert property (@(posedge clk) disable iff (rst)
    fwd_hit |-> s1_valid)
    else $error("forwarded line word without an item in stage one");
  a_rem_in_range : assert property (@(posedge clk) disable iff (rst)
    s4_valid |-> rem_fix < SUM_W'(AREA))
    else $error("mean correction left a remainder out of range");
`endif

endmodule

FILE: test/tb_box_average_filter.sv
// ============================================================================
// tb_box_average_filter
// Self-checking testbench for the streaming 3x3 box average filter.
// ============================================================================
// Pixels go in on the pix channel and window means come back on the res
// channel. An internal model of the line buffers, the window and the
// row/column counters predicts every mean, and each result transfer is
// compared field by field with the oldest prediction. A short table of
// directed frames comes first. Random frames follow, with random widths,
// restarts and partial rows. Both sides idle at random until the last phase.
// ============================================================================
module tb_box_average_filter;
  timeunit 1ns;
  timeprecision 1ps;

  import baf_pkg::*;

  // Geometry of the filter under test. The model below is written for any
  // radius, but the instance uses the default of one.
  localparam int RAD   = 1;
  localparam int SIDE  = 2 * RAD + 1;
  localparam int LINES = 2 * RAD;
  localparam int AREA  = SIDE * SIDE;
  localparam int MAXW  = 1024;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int SETTLE       = 20;    // idle cycles before a register write
  localparam int MAX_GAP      = 20;    // longest sender gap between pixels
  localparam int RANDOM_ITEMS = 1130;
  localparam int REPORT_MAX   = 10;

  localparam logic [2:0] WIDTH_ADDR = {REG_IMAGE_WIDTH, 2'b00};

  // One row of the directed table. The pixel is sent count times in a row;
  // frame_start applies to the first copy only, and a typed mean, where
  // given, is the expected mean of the result caused by the last copy.
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             fs;
    logic [3:0]       count;
    logic             typed;
    logic [PIX_W-1:0] mean;
  } stim_row_t;

  // All directed frames run at width 3, so each row is three pixels.
  localparam stim_row_t DIRECTED_ROWS [10] = '{
    // A flat white frame: the first full window averages to full scale.
    '{8'hFF, 1'b1, 4'd1, 1'b0, 8'd0},
    '{8'hFF, 1'b0, 4'd7, 1'b0, 8'd0},
    '{8'hFF, 1'b0, 4'd1, 1'b1, 8'd255},
    // A black fourth row: six whites and three blacks give 1530 / 9.
    '{8'h00, 1'b0, 4'd2, 1'b0, 8'd0},
    '{8'h00, 1'b0, 4'd1, 1'b1, 8'd170},
    // Two pixels into the fifth row, then a new frame starts mid-row.
    '{8'h00, 1'b0, 4'd2, 1'b0, 8'd0},
    '{8'h00, 1'b1, 4'd1, 1'b0, 8'd0},
    '{8'h00, 1'b0, 4'd7, 1'b0, 8'd0},
    // The old white lines must not leak into the new frame's first window.
    '{8'h00, 1'b0, 4'd1, 1'b1, 8'd0},
    '{8'h01, 1'b0, 4'd1, 1'b0, 8'd0}
  };

  logic        clk = 1'b0;
  logic        rst;
  logic        pix_valid;
  logic        pix_stall;
  pixel_in_t   pix_data;
  logic        res_valid;
  logic        res_stall = 1'b0;
  result_t     res_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // A typed mean travels beside the pixel that causes it, so that it lines
  // up with the transfer without a separate queue.
  logic             typed_on;
  logic [PIX_W-1:0] typed_mean;

  int  send_idle_pct;
  int  recv_idle_pct;
  bit  hold_off;
  int  error_count = 0;
  int  cycle_count = 0;
  int  pixels_sent = 0;

  // State of the filter model: the line buffers (oldest row first), the
  // window (leftmost column first), the position of the arriving pixel and
  // the programmed width.
  logic [PIX_W-1:0] line_mem [LINES][MAXW];
  logic [PIX_W-1:0] win      [SIDE][SIDE];
  int unsigned      cur_row;
  int unsigned      cur_col;
  logic [CFG_W-1:0] img_width;

  // Window means still owed by the block, oldest first.
  result_t means_due [$];

  box_average_filter #(
    .RADIUS    (RAD),
    .MAX_WIDTH (MAXW)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix_data  (pix_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog: a correct run ends far below this count.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_box_average_filter failed");
      $finish;
    end
  end

  // The receiver stalls at random, except while the testbench lets the
  // pipeline empty ahead of a register write or the end of the run.
  always @(posedge clk) begin
    if (hold_off) begin
      res_stall <= 1'b0;
    end else begin
      res_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic note_failure(input string msg);
    error_count++;
    if (error_count <= REPORT_MAX) begin
      $display("[%0t] %s", $realtime, msg);
    end
  endtask

  // Width the counters actually wrap at: zero acts as one, and anything
  // above the line buffer size is clipped to it.
  function automatic int unsigned active_width();
    if (img_width == '0) return 1;
    if (img_width > MAXW) return MAXW;
    return 32'(img_width);
  endfunction

  // Advances the model by one pixel and reports the mean it gives, if any.
  task automatic slide_window(input pixel_in_t item, output bit emits,
                              output result_t mean_out);
    logic [PIX_W-1:0] column [SIDE];
    int unsigned      c;
    int unsigned      sum;
    emits    = 1'b0;
    mean_out = '0;
    if (item.frame_start) begin
      cur_row = 0;
      cur_col = 0;
    end
    c = (cur_col >= MAXW) ? MAXW - 1 : cur_col;

    // Read the vertical column at this position, then push the new pixel
    // into the bottom line and move the older lines up by one.
    for (int k = 0; k < LINES; k++) column[k] = line_mem[k][c];
    column[LINES] = item.pixel;
    for (int k = 0; k < LINES - 1; k++) line_mem[k][c] = line_mem[k+1][c];
    line_mem[LINES-1][c] = item.pixel;

    for (int y = 0; y < SIDE; y++) begin
      for (int x = 0; x < SIDE - 1; x++) win[y][x] = win[y][x+1];
      win[y][SIDE-1] = column[y];
    end

    // The window is complete once the arriving pixel is past the top and
    // left borders; the result is tagged with the centre position.
    if (cur_row >= LINES && cur_col >= LINES) begin
      sum = 0;
      for (int y = 0; y < SIDE; y++)
        for (int x = 0; x < SIDE; x++) sum += win[y][x];
      emits               = 1'b1;
      mean_out.mean_value = PIX_W'(sum / AREA);
      mean_out.centre_row = ROW_W'(cur_row - RAD);
      mean_out.centre_col = COL_OUT_W'(cur_col - RAD);
    end

    cur_col++;
    if (cur_col >= active_width()) begin
      cur_col = 0;
      cur_row = (cur_row + 1) % (1 << ROW_W);
    end
  endtask

  // Both channels are watched in one block so that the prediction for a
  // pixel is always queued before any result in the same clock is checked.
  always @(posedge clk) begin : transfer_watch
    bit      emits;
    result_t due;
    if (!rst && pix_valid && !pix_stall) begin
      slide_window(pix_data, emits, due);
      if (emits) begin
        if (typed_on) due.mean_value = typed_mean;
        means_due.push_back(due);
      end
    end
    if (!rst && res_valid && !res_stall) begin
      if (means_due.size() == 0) begin
        note_failure($sformatf("result with nothing expected: mean %0d at (%0d,%0d)",
                               res_data.mean_value, res_data.centre_row,
                               res_data.centre_col));
      end else begin
        due = means_due.pop_front();
        if (res_data.mean_value !== due.mean_value)
          note_failure($sformatf("mean_value at (%0d,%0d): expected %0d, got %0d",
                                 due.centre_row, due.centre_col,
                                 due.mean_value, res_data.mean_value));
        if (res_data.centre_row !== due.centre_row)
          note_failure($sformatf("centre_row: expected %0d, got %0d",
                                 due.centre_row, res_data.centre_row));
        if (res_data.centre_col !== due.centre_col)
          note_failure($sformatf("centre_col at row %0d: expected %0d, got %0d",
                                 due.centre_row, due.centre_col,
                                 res_data.centre_col));
      end
    end
  end

  // Offers one pixel, after a random gap, and holds it until the transfer.
  // The gap length is chosen up front so that pix_valid gets a single
  // assignment in any one clock.
  task automatic send_pixel(input logic [PIX_W-1:0] p, input logic fs,
                            input logic typed, input logic [PIX_W-1:0] m);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      pix_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_valid  <= 1'b1;
    pix_data   <= {p, fs};
    typed_on   <= typed;
    typed_mean <= m;
    do @(posedge clk); while (pix_stall);
    pixels_sent++;
  endtask

  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  // Sends n_rows full rows plus a partial one at the current width. A frame
  // may leave out its leading frame_start (it then continues the previous
  // one) or restart somewhere in the middle. One frame in ten is flat.
  task automatic run_frame(input int n_rows, input int extra, input bit lead_fs,
                           input bit restart);
    int               total;
    int               restart_at;
    bit               flat_on;
    logic [PIX_W-1:0] flat_val;
    total      = n_rows * active_width() + extra;
    restart_at = restart ? $urandom_range(total - 1) : -1;
    flat_on    = ($urandom_range(9) == 0);
    flat_val   = $urandom_range(1) ? '1 : PIX_W'($urandom);
    for (int i = 0; i < total; i++)
      send_pixel(flat_on ? flat_val : pick_pixel(),
                 (i == 0 && lead_fs) || i == restart_at, 1'b0, '0);
  endtask

  // Lets every owed result arrive, then gives the pipeline time to empty of
  // border pixels, which leave no trace on the result channel.
  task automatic drain();
    pix_valid <= 1'b0;
    while (means_due.size() != 0) @(posedge clk);
    hold_off = 1'b1;
    repeat (SETTLE) @(posedge clk);
    hold_off = 1'b0;
  endtask

  task automatic read_width(output logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= WIDTH_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    value = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Writes image_width while the block is idle and reads it back. The read
  // setup follows the write access directly, so psel stays high.
  task automatic set_width(input logic [CFG_W-1:0] v);
    logic [31:0] rd;
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= WIDTH_ADDR;
    pwdata  <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    img_width = v;
    read_width(rd);
    if (rd !== 32'(v))
      note_failure($sformatf("image_width read back %0d after writing %0d", rd, v));
  endtask

  // Random frames until count more pixels have gone in. Most frames are
  // small and well formed; some change the width, some skip the leading
  // frame_start, some restart mid-frame and some stop before any window.
  task automatic random_frames(input int count);
    int stop;
    bit changed;
    int n_rows;
    stop = pixels_sent + count;
    while (pixels_sent < stop) begin
      changed = ($urandom_range(9) < 6);
      if (changed) begin
        case ($urandom_range(19))
          0:          set_width(CFG_W'($urandom_range(65, 100)));
          1, 2, 3, 4: set_width(CFG_W'($urandom_range(13, 64)));
          default:    set_width(CFG_W'($urandom_range(3, 12)));
        endcase
      end
      n_rows = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 6);
      // A frame without frame_start is only legal when the width is unchanged.
      run_frame(n_rows, $urandom_range(active_width() - 1),
                changed || ($urandom_range(99) >= 15), $urandom_range(9) == 0);
    end
  endtask

  initial begin : stimulus
    logic [31:0] rd;

    rst        = 1'b1;
    pix_valid  = 1'b0;
    pix_data   = '0;
    typed_on   = 1'b0;
    typed_mean = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    hold_off   = 1'b0;

    // The model starts from the reset state; the line buffers hold zero,
    // although no compared result ever depends on them before they are
    // written.
    for (int k = 0; k < LINES; k++)
      for (int c = 0; c < MAXW; c++) line_mem[k][c] = '0;
    for (int y = 0; y < SIDE; y++)
      for (int x = 0; x < SIDE; x++) win[y][x] = '0;
    cur_row   = 0;
    cur_col   = 0;
    img_width = IMAGE_WIDTH_RESET;

    // Sender idles often, receiver stalls more often still.
    send_idle_pct = 31;
    recv_idle_pct = 67;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    read_width(rd);
    if (rd !== 32'(IMAGE_WIDTH_RESET))
      note_failure($sformatf("image_width after reset reads %0d", rd));

    // Directed frames at the smallest width that yields a window.
    set_width(CFG_W'(3));
    foreach (DIRECTED_ROWS[i]) begin
      for (int k = 0; k < DIRECTED_ROWS[i].count; k++)
        send_pixel(DIRECTED_ROWS[i].pixel, DIRECTED_ROWS[i].fs && k == 0,
                   DIRECTED_ROWS[i].typed && k == DIRECTED_ROWS[i].count - 1,
                   DIRECTED_ROWS[i].mean);
    end

    // Widths of zero, one and two never complete a window, so any result
    // during these frames is a failure.
    for (int v = 0; v < 3; v++) begin
      set_width(CFG_W'(v));
      run_frame(30 / active_width(), 0, 1'b1, 1'b0);
    end

    random_frames(RANDOM_ITEMS / 3);

    // Now the sender is the busy side and the receiver stalls less.
    send_idle_pct = 67;
    recv_idle_pct = 31;

    random_frames(RANDOM_ITEMS / 3);

    // Back-to-back transfers with no stalls on either side.
    send_idle_pct = 0;
    recv_idle_pct = 0;

    random_frames(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

    drain();
    if (error_count == 0 && means_due.size() == 0) begin
      $display("tb_box_average_filter passed");
    end else begin
      $display("tb_box_average_filter failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/baf_pkg.sv
design/baf_front.sv
design/baf_queue.sv
design/baf_back.sv
design/box_average_filter.sv
test/tb_box_average_filter.sv
